@@ rtl/lfq_pkg.sv @@
// Shared types, constants and the QoS class function for the L2 learning forwarder.
// No dependencies.
package lfq_pkg;

  localparam logic [15:0] ETH_LLDP       = 16'h88CC;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [15:0] PORT_ISCSI     = 16'd3260;
  localparam logic [15:0] PORT_LOW_A     = 16'd5001;
  localparam logic [15:0] PORT_LOW_B     = 16'd5060;
  localparam logic [15:0] PORT_LOW_C     = 16'd6000;
  localparam logic [15:0] PORT_LOW_D     = 16'd6002;
  localparam int          MCAST_BIT      = 40;

  localparam logic [1:0]  PRIO_NONE      = 2'd0;
  localparam logic [1:0]  PRIO_HIGH      = 2'd1;
  localparam logic [1:0]  PRIO_LOW       = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } lfq_state_t;

  // broadcast to every cell: the clear strobe and the item registers
  typedef struct packed {
    logic        clear;
    logic        learn;
    logic        look;
    logic [47:0] src;
    logic [47:0] dst;
    logic [15:0] in_port;
  } lfq_bcast_t;

  // token handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        src_found;
    logic        free_seen;
    logic        dst_found;
    logic [15:0] dst_port;
  } lfq_tok_t;

  typedef struct packed {
    logic [8:0]  learned_count;
    logic [15:0] egress_port;
    logic        flood;
    logic        attach_data;
    logic        send_packet_out;
    logic [1:0]  priority_class;
    logic        install_flow;
  } lfq_res_t;

  function automatic logic [1:0] lfq_prio(input logic [7:0] proto,
                                          input logic [15:0] sp,
                                          input logic [15:0] dp);
    logic [1:0] p;
    p = PRIO_NONE;
    if (proto == PROTO_TCP && (sp == PORT_ISCSI || dp == PORT_ISCSI))
      p = PRIO_HIGH;
    else if (sp == PORT_LOW_A || dp == PORT_LOW_A || sp == PORT_LOW_B ||
             dp == PORT_LOW_B || sp == PORT_LOW_C || dp == PORT_LOW_C ||
             sp == PORT_LOW_D || dp == PORT_LOW_D)
      p = PRIO_LOW;
    return p;
  endfunction

endpackage

@@ rtl/lfq_cell.sv @@
// One table entry of the forwarder: MAC, port and valid bit, with learn and match logic.
// Depends on lfq_pkg.
module lfq_cell
  import lfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lfq_bcast_t bc,
  input  lfq_tok_t   tok_i,
  output lfq_tok_t   tok_o
);

  logic        valid_r;
  logic [47:0] mac_r;
  logic [15:0] port_r;
  lfq_tok_t    tok_r;
  lfq_tok_t    tok_nxt;

  logic        hit_src;
  logic        ins;
  logic        valid_a;
  logic [47:0] mac_a;
  logic [15:0] port_a;
  logic        hit_dst;

  always_comb begin
    hit_src = tok_i.active && valid_r && bc.learn && (mac_r == bc.src);
    // first free slot: all later slots are free too
    ins     = tok_i.active && !valid_r && !tok_i.free_seen && bc.learn && !tok_i.src_found;
    valid_a = valid_r | ins;
    mac_a   = ins ? bc.src : mac_r;
    port_a  = (hit_src || ins) ? bc.in_port : port_r;
    hit_dst = tok_i.active && valid_a && bc.look && (mac_a == bc.dst);

    tok_nxt.active    = tok_i.active;
    tok_nxt.src_found = tok_i.src_found | hit_src;
    tok_nxt.free_seen = tok_i.free_seen | (tok_i.active && !valid_r);
    tok_nxt.dst_found = tok_i.dst_found | hit_dst;
    tok_nxt.dst_port  = hit_dst ? port_a : tok_i.dst_port;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      if (bc.clear)
        valid_r <= 1'b0;
      else if (ins)
        valid_r <= 1'b1;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ins)
      mac_r <= bc.src;
    if (hit_src || ins)
      port_r <= bc.in_port;
  end

  assign tok_o = tok_r;

endmodule

@@ rtl/l2_learning_forwarder_qos.sv @@
// Top level of the L2 learning forwarder with QoS marking: item registers, control
// FSM, result logic and the row of lfq_cell entries. Depends on lfq_pkg and lfq_cell.
//
// One item is in work at a time. A packet header launches a token that walks the
// row of TABLE_ENTRIES cells, one cell per cycle, learning the source and matching
// the destination on the way; its result goes to the hold register when the token
// leaves the last cell and from there to the output register, and the next item is
// taken only once the result has moved on to the output register.
// A clear command or an LLDP frame skips the walk: its result goes straight to the
// hold register and from there to the output register. The clear
// empties the table in the cycle it is accepted. Input is taken while a finished
// result still waits on the output; the next result then waits until that one has gone.
module l2_learning_forwarder_qos
  import lfq_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,    // enable_flow_setup
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata from bit 0: in_port[15:0], src_mac[63:16], dst_mac[111:64],
  // eth_type[127:112], ip_proto[135:128], l4_src_port[151:136],
  // l4_dst_port[167:152], is_buffered[168], data_complete[169], zero pad
  input  logic [175:0] in_tdata,
  input  logic         in_tuser,       // func
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata from bit 0: install_flow[0], priority_class[2:1],
  // send_packet_out[3], attach_data[4], flood[5], egress_port[21:6],
  // learned_count[30:22], zero pad
  output logic [31:0]  out_tdata
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  lfq_state_t  state_r, state_nxt;
  logic        flow_en_r;
  logic [CW-1:0] count_r;
  logic        start_r;

  logic [47:0] src_r, dst_r;
  logic [15:0] in_port_r, sp_r, dp_r;
  logic [7:0]  proto_r;
  logic        buf_r, comp_r, learn_r, look_r;

  lfq_res_t    hold_r;
  lfq_res_t    res_fin;
  lfq_res_t    res_direct;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic        in_acc;
  logic        func_w;
  logic        direct_w;
  logic        out_free;
  logic        load_out;
  logic        fin;
  logic        fin_ins;
  logic [CW-1:0] count_fin;
  logic        known;

  lfq_bcast_t  bc;
  lfq_tok_t    tok [TABLE_ENTRIES+1];

  assign func_w   = in_tuser;
  assign direct_w = func_w || (in_tdata[127:112] == ETH_LLDP);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign fin      = tok[TABLE_ENTRIES].active;

  always_comb begin
    bc.clear   = in_acc && func_w;
    bc.learn   = learn_r;
    bc.look    = look_r;
    bc.src     = src_r;
    bc.dst     = dst_r;
    bc.in_port = in_port_r;
  end

  assign tok[0] = '{active: start_r, src_found: 1'b0, free_seen: 1'b0,
                    dst_found: 1'b0, dst_port: 16'd0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lfq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .bc    (bc),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // result of a finished walk, and of a clear or LLDP item
  always_comb begin
    fin_ins   = tok[TABLE_ENTRIES].free_seen && learn_r && !tok[TABLE_ENTRIES].src_found;
    count_fin = count_r + CW'(fin_ins);
    known     = tok[TABLE_ENTRIES].dst_found;

    res_fin.install_flow    = flow_en_r && known;
    res_fin.priority_class  = (flow_en_r && known) ? lfq_prio(proto_r, sp_r, dp_r) : PRIO_NONE;
    res_fin.send_packet_out = 1'b0;
    res_fin.attach_data     = 1'b0;
    res_fin.flood           = 1'b0;
    if ((!flow_en_r || !known || !buf_r) && (buf_r || comp_r)) begin
      res_fin.send_packet_out = 1'b1;
      res_fin.attach_data     = !buf_r;
      res_fin.flood           = !known;
    end
    res_fin.egress_port   = known ? tok[TABLE_ENTRIES].dst_port : 16'd0;
    res_fin.learned_count = 9'(count_fin);

    res_direct               = '0;
    res_direct.learned_count = func_w ? 9'd0 : 9'(count_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc)
          state_nxt = direct_w ? ST_HOLD : ST_RUN;
      end
      ST_RUN: begin
        if (fin)
          state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free)
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_HOLD: load_out  = out_free;
      default: begin
        in_tready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flow_en_r   <= 1'b1;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc && !direct_w;
      if (cfg_wr_en)
        flow_en_r <= cfg_wr_data;
      if (in_acc && func_w)
        count_r <= '0;
      else if (fin)
        count_r <= count_fin;
      if (load_out)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_port_r <= in_tdata[15:0];
      src_r     <= in_tdata[63:16];
      dst_r     <= in_tdata[111:64];
      proto_r   <= in_tdata[135:128];
      sp_r      <= in_tdata[151:136];
      dp_r      <= in_tdata[167:152];
      buf_r     <= in_tdata[168];
      comp_r    <= in_tdata[169];
      learn_r   <= !in_tdata[16 + MCAST_BIT];
      look_r    <= !in_tdata[64 + MCAST_BIT];
    end
    if (in_acc && direct_w)
      hold_r <= res_direct;
    else if (fin)
      hold_r <= res_fin;
    if (load_out)
      out_data_r <= {1'b0, hold_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("learned count above table size");

  a_fin_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> state_r == ST_RUN)
    else $error("token left the cell row outside a walk");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func_w) |=> count_r == '0)
    else $error("clear did not empty the table count");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && fin_ins) |=> count_r == $past(count_r) + CW'(1))
    else $error("insertion did not advance the count");

endmodule

@@ tb/sv/tb_l2_learning_forwarder_qos.sv @@
// Self-checking bench for l2_learning_forwarder_qos: learning, lookup, QoS class,
// packet-out rules, table clear and table-full behaviour, with random stalls on both sides.
// Depends on rtl/lfq_pkg.sv and the forwarder RTL.
module tb_l2_learning_forwarder_qos;
  timeunit 1ns;
  timeprecision 1ps;
  import lfq_pkg::*;

  localparam int          TBL_DEPTH   = 256;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MAC_A       = 48'h00_1B_21_3A_4C_5D;
  localparam logic [47:0] MAC_B       = 48'h02_00_5E_10_20_30;
  localparam logic [47:0] MAC_C       = 48'h00_00_00_00_00_01;
  localparam logic [47:0] MAC_D       = 48'h00_AA_00_00_00_02;

  typedef struct {
    logic        func;
    logic [15:0] in_port;
    logic [47:0] src;
    logic [47:0] dst;
    logic [15:0] eth_type;
    logic [7:0]  proto;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        buffered;
    logic        complete;
  } hdr_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;

  hdr_t        header_q[$];
  lfq_res_t    decision_q[$];
  hdr_t        cur_hdr;
  logic        in_fire = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold_left = 0;
  logic        tx_pause = 1'b0;
  int          cycles = 0;
  int          mismatches = 0;
  int          headers_taken = 0;
  int          decisions_seen = 0;

  // bench copy of the forwarding table and register
  logic        flow_en = 1'b1;
  logic [47:0] mac_tbl[TBL_DEPTH];
  logic [15:0] port_tbl[TBL_DEPTH];
  logic        mac_valid[TBL_DEPTH];
  int          mac_count = 0;
  int          peak_count = 0;
  logic [47:0] mac_pool[16];

  l2_learning_forwarder_qos #(.TABLE_ENTRIES(TBL_DEPTH)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic hdr_t mk(input logic func, input logic [15:0] port,
                              input logic [47:0] src, input logic [47:0] dst,
                              input logic [15:0] eth, input logic [7:0] proto,
                              input logic [15:0] sp, input logic [15:0] dp,
                              input logic buffered, input logic complete);
    hdr_t h;
    h.func = func;
    h.in_port = port;
    h.src = src;
    h.dst = dst;
    h.eth_type = eth;
    h.proto = proto;
    h.sp = sp;
    h.dp = dp;
    h.buffered = buffered;
    h.complete = complete;
    return h;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [15:0] pick_l4();
    case ($urandom_range(0, 7))
      0: return PORT_ISCSI;
      1: return PORT_LOW_A;
      2: return PORT_LOW_B;
      3: return PORT_LOW_C;
      4: return PORT_LOW_D;
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed traffic from a small host pool, or raw noise
  function automatic hdr_t rand_hdr(input logic noisy);
    hdr_t h;
    int   r;
    if (noisy) begin
      h = mk($urandom_range(0, 9) == 0, 16'($urandom), rand_mac(), rand_mac(),
             16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom), 1'($urandom));
    end else begin
      h = mk($urandom_range(0, 99) < 2, 16'($urandom_range(1, 6)),
             mac_pool[$urandom_range(0, 15)], mac_pool[$urandom_range(0, 15)],
             ETH_IPV4, PROTO_TCP, pick_l4(), pick_l4(), 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 4) == 0)
        h.in_port = 16'($urandom);
      r = $urandom_range(0, 19);
      if (r == 0)
        h.dst = BCAST_MAC;
      else if (r == 1)
        h.dst = rand_mac() & ~(48'd1 << MCAST_BIT);
      r = $urandom_range(0, 19);
      if (r == 0)
        h.eth_type = ETH_LLDP;
      else if (r == 1)
        h.eth_type = 16'($urandom);
      r = $urandom_range(0, 3);
      if (r == 0)
        h.proto = PROTO_UDP;
      else if (r == 1)
        h.proto = 8'($urandom);
    end
    return h;
  endfunction

  function automatic int mac_slot(input logic [47:0] mac);
    for (int i = 0; i < TBL_DEPTH; i++)
      if (mac_valid[i] && mac_tbl[i] == mac)
        return i;
    return -1;
  endfunction

  function automatic logic on_port(input hdr_t h, input logic [15:0] p);
    return h.sp == p || h.dp == p;
  endfunction

  function automatic logic [1:0] qos_class(input hdr_t h);
    if (h.proto == PROTO_TCP && on_port(h, PORT_ISCSI))
      return PRIO_HIGH;
    if (on_port(h, PORT_LOW_A) || on_port(h, PORT_LOW_B) || on_port(h, PORT_LOW_C) ||
        on_port(h, PORT_LOW_D))
      return PRIO_LOW;
    return PRIO_NONE;
  endfunction

  task automatic predict_forward(input hdr_t h);
    lfq_res_t    r;
    int          s;
    logic        known;
    logic        placed;
    logic [15:0] oport;
    r = '0;
    known = 1'b0;
    placed = 1'b0;
    oport = '0;
    if (h.func) begin
      for (int i = 0; i < TBL_DEPTH; i++)
        mac_valid[i] = 1'b0;
      mac_count = 0;
    end else if (h.eth_type != ETH_LLDP) begin
      if (!h.src[MCAST_BIT]) begin
        s = mac_slot(h.src);
        if (s >= 0) begin
          port_tbl[s] = h.in_port;
        end else if (mac_count < TBL_DEPTH) begin
          for (int i = 0; i < TBL_DEPTH; i++) begin
            if (!placed && !mac_valid[i]) begin
              mac_valid[i] = 1'b1;
              mac_tbl[i] = h.src;
              port_tbl[i] = h.in_port;
              mac_count++;
              placed = 1'b1;
            end
          end
        end
      end
      if (!h.dst[MCAST_BIT]) begin
        s = mac_slot(h.dst);
        if (s >= 0) begin
          known = 1'b1;
          oport = port_tbl[s];
        end
      end
      if (flow_en && known) begin
        r.install_flow = 1'b1;
        r.priority_class = qos_class(h);
      end
      if ((!flow_en || !known || !h.buffered) && (h.buffered || h.complete)) begin
        r.send_packet_out = 1'b1;
        r.attach_data = !h.buffered;
        r.flood = !known;
      end
      r.egress_port = oport;
    end
    r.learned_count = 9'(mac_count);
    if (mac_count > peak_count)
      peak_count = mac_count;
    decision_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // sample side: compare delivered decisions, then predict for the accepted header
  always @(posedge clk) begin
    lfq_res_t want;
    lfq_res_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_n) begin
      if (out_tvalid && out_tready) begin
        decisions_seen++;
        got = lfq_res_t'(out_tdata[30:0]);
        if (decision_q.size() == 0) begin
          $error("unexpected decision word %h", out_tdata);
          mismatches++;
        end else begin
          want = decision_q.pop_front();
          check_field("install_flow", want.install_flow, got.install_flow);
          check_field("priority_class", want.priority_class, got.priority_class);
          check_field("send_packet_out", want.send_packet_out, got.send_packet_out);
          check_field("attach_data", want.attach_data, got.attach_data);
          check_field("flood", want.flood, got.flood);
          check_field("egress_port", want.egress_port, got.egress_port);
          check_field("learned_count", want.learned_count, got.learned_count);
        end
      end
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        headers_taken++;
        predict_forward(cur_hdr);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (header_q.size() > 0 && !tx_pause && $urandom_range(0, 99) >= tx_idle_pct) begin
        cur_hdr = header_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= cur_hdr.func;
        in_tdata <= {6'b0, cur_hdr.complete, cur_hdr.buffered, cur_hdr.dp, cur_hdr.sp,
                     cur_hdr.proto, cur_hdr.eth_type, cur_hdr.dst, cur_hdr.src,
                     cur_hdr.in_port};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_tready <= $urandom_range(0, 99) >= rx_idle_pct;
    end
  end

  task automatic drain();
    while (header_q.size() != 0 || in_tvalid || decision_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_flow_en(input logic v);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    flow_en = v;
    @(posedge clk);
  endtask

  initial begin
    hdr_t h;
    int   k;
    for (int i = 0; i < TBL_DEPTH; i++)
      mac_valid[i] = 1'b0;
    for (int i = 0; i < 16; i++)
      mac_pool[i] = rand_mac() & ~(48'd1 << MCAST_BIT);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed, flow setup at its reset value
    tx_idle_pct = 17;
    rx_idle_pct = 66;
    header_q.push_back(mk(0, 16'h0000, MAC_A, MAC_B, ETH_IPV4, PROTO_TCP, 1234, 80, 1, 0));
    header_q.push_back(mk(0, 16'hFFFF, MAC_B, MAC_A, ETH_IPV4, PROTO_TCP, 40000, PORT_ISCSI,
                          1, 1));
    header_q.push_back(mk(0, 3, MAC_A, MAC_B, ETH_IPV4, PROTO_UDP, PORT_ISCSI, 9, 0, 1));
    header_q.push_back(mk(0, 5, MAC_A, MAC_B, ETH_IPV4, PROTO_UDP, PORT_LOW_A, 7, 0, 0));
    header_q.push_back(mk(0, 5, MAC_A, MAC_B, ETH_IPV4, PROTO_TCP, 7, PORT_LOW_B, 1, 0));
    header_q.push_back(mk(0, 5, MAC_A, MAC_B, ETH_IPV4, PROTO_UDP, PORT_LOW_C, 7, 1, 0));
    header_q.push_back(mk(0, 6, MAC_B, MAC_A, ETH_IPV4, PROTO_TCP, 7, PORT_LOW_D, 0, 1));
    header_q.push_back(mk(0, 6, MAC_B, MAC_A, ETH_IPV4, PROTO_TCP, PORT_ISCSI, PORT_LOW_A,
                          1, 1));
    header_q.push_back(mk(0, 8, MAC_C, MAC_A, ETH_LLDP, PROTO_TCP, 1, 2, 1, 1));
    header_q.push_back(mk(0, 9, BCAST_MAC, MAC_A, ETH_IPV4, PROTO_TCP, 1, 2, 1, 1));
    header_q.push_back(mk(0, 10, MAC_C, BCAST_MAC, ETH_IPV4, PROTO_UDP, 1, 2, 0, 1));
    header_q.push_back(mk(0, 16'h1234, 48'h0, 48'h0, ETH_IPV4, PROTO_TCP, 0, 0, 1, 1));
    header_q.push_back(mk(0, 7, MAC_B, MAC_B, ETH_IPV4, PROTO_TCP, 1, 2, 0, 1));
    header_q.push_back(mk(0, 2, MAC_A, MAC_D, ETH_IPV4, PROTO_TCP, 1, 2, 0, 0));
    header_q.push_back(mk(0, 16'hFFFF, BCAST_MAC, BCAST_MAC, 16'hFFFF, 8'hFF, 16'hFFFF,
                          16'hFFFF, 1, 1));
    header_q.push_back(mk(0, 11, MAC_D, MAC_C, 16'h88CD, PROTO_TCP, 1, 2, 1, 0));
    header_q.push_back(mk(1, 16'hFFFF, BCAST_MAC, BCAST_MAC, 16'hFFFF, 8'hFF, 16'hFFFF,
                          16'hFFFF, 1, 1));
    header_q.push_back(mk(0, 12, MAC_C, MAC_A, ETH_IPV4, PROTO_TCP, 1, 2, 1, 1));

    // forwarding only
    write_flow_en(1'b0);
    header_q.push_back(mk(0, 2, MAC_A, MAC_C, ETH_IPV4, PROTO_TCP, PORT_ISCSI, 2, 1, 0));
    header_q.push_back(mk(0, 2, MAC_A, MAC_C, ETH_IPV4, PROTO_TCP, 1, 2, 0, 0));
    header_q.push_back(mk(0, 4, MAC_C, MAC_A, ETH_IPV4, PROTO_UDP, 1, PORT_LOW_D, 0, 1));
    for (k = 0; k < 60; k++)
      header_q.push_back(rand_hdr($urandom_range(0, 99) < 15));

    // flow setup on, fill the table past capacity under a long output stall
    write_flow_en(1'b1);
    tx_idle_pct = 66;
    rx_idle_pct = 17;
    header_q.push_back(mk(1, 0, MAC_A, MAC_A, ETH_IPV4, PROTO_TCP, 0, 0, 0, 0));
    for (k = 0; k < 280; k++) begin
      h = rand_hdr(1'b0);
      h.func = 1'b0;
      h.eth_type = ETH_IPV4;
      if (k % 10 != 9)
        h.src = {8'h02, 8'h5A, 16'h0, 16'(k)};
      if ($urandom_range(0, 1) == 0)
        h.dst = {8'h02, 8'h5A, 16'h0, 16'($urandom_range(0, k))};
      header_q.push_back(h);
    end
    for (k = 0; k < 40; k++)
      header_q.push_back(rand_hdr($urandom_range(0, 99) < 15));
    while (!in_tvalid)
      @(posedge clk);
    rx_hold_left = 700;

    // forwarding only again, no idling; sender halts mid-way until all is delivered
    write_flow_en(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (k = 0; k < 50; k++)
      header_q.push_back(rand_hdr($urandom_range(0, 99) < 15));
    while (header_q.size() > 25)
      @(posedge clk);
    tx_pause = 1'b1;
    while (in_tvalid || decision_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    tx_pause = 1'b0;

    drain();
    repeat (TBL_DEPTH + 20) @(posedge clk);
    $display("Checked %0d decisions for %0d headers and clears; table peaked at %0d of %0d",
             decisions_seen, headers_taken, peak_count, TBL_DEPTH);
    $display("entries, flow setup toggled on and off, with stalls on both sides.");
    if (mismatches == 0 && decision_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lfq_pkg.sv
rtl/lfq_cell.sv
rtl/l2_learning_forwarder_qos.sv
tb/sv/tb_l2_learning_forwarder_qos.sv
